// ===== sv/spims_pkg.sv =====
package spims_pkg;

    localparam int HALF_W    = 16;
    localparam int TICK_W    = 24;
    localparam int RBC_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [HALF_W-1:0] HALF_RESET    = 16'd25;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd1000000;
    localparam logic [TICK_W-1:0] SETTLE_RESET  = 24'd50000;
    localparam logic [7:0]        IR_BYTE       = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HALF    = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_SETTLE  = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CMD_NONE     = 3'd0,
        CMD_XFER     = 3'd1,
        CMD_SELECT   = 3'd2,
        CMD_DESELECT = 3'd3,
        CMD_SET_RST  = 3'd4,
        CMD_WAIT_RDY = 3'd5,
        CMD_IF_RESET = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        OP_IDLE      = 3'd0,
        OP_XFER      = 3'd1,
        OP_CSWAIT    = 3'd2,
        OP_READY     = 3'd3,
        OP_IR_SEL    = 3'd4,
        OP_IR_XFER   = 3'd5,
        OP_IR_DESEL  = 3'd6,
        OP_IR_SETTLE = 3'd7
    } op_t;

    typedef struct packed {
        logic [HALF_W-1:0] half_period_ticks;
        logic [TICK_W-1:0] ready_timeout_ticks;
        logic [TICK_W-1:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] pad;
        logic       drdy_n;
        logic       miso;
        logic       reset_level;
        logic [7:0] tx_byte;
        logic [2:0] command;
    } item_t;

    typedef struct packed {
        logic       timed_out;
        logic       ready_seen;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       adc_reset;
        logic       cs_n;
        logic       mosi;
        logic       sck;
    } result_t;

endpackage

// ===== sv/spims_cfg.sv =====
module spims_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [spims_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spims_pkg::TICK_W-1:0]    cfg_data,
    output spims_pkg::cfg_t             cfg
);

    spims_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks   <= spims_pkg::HALF_RESET;
            cfg_reg.ready_timeout_ticks <= spims_pkg::TIMEOUT_RESET;
            cfg_reg.settle_ticks        <= spims_pkg::SETTLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                spims_pkg::CFG_HALF:
                    cfg_reg.half_period_ticks <= cfg_data[spims_pkg::HALF_W-1:0];
                spims_pkg::CFG_TIMEOUT:
                    cfg_reg.ready_timeout_ticks <= cfg_data;
                spims_pkg::CFG_SETTLE:
                    cfg_reg.settle_ticks <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== sv/spims_core.sv =====
module spims_core #(
    parameter int COUNTER_BITS = 24,
    parameter int RESET_BYTES  = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  spims_pkg::item_t    item,
    input  spims_pkg::cfg_t     cfg,
    output spims_pkg::result_t  res
);

    localparam int WL = (COUNTER_BITS > spims_pkg::TICK_W) ? COUNTER_BITS : spims_pkg::TICK_W;
    localparam logic [WL-1:0] CNT_MAX = WL'({COUNTER_BITS{1'b1}});

    function automatic logic [COUNTER_BITS-1:0] wait_load(input logic [spims_pkg::TICK_W-1:0] ticks);
        logic [WL-1:0] t;
        t = WL'(ticks) - WL'(ticks != '0);
        if (t > CNT_MAX)
            return CNT_MAX[COUNTER_BITS-1:0];
        return t[COUNTER_BITS-1:0];
    endfunction

    spims_pkg::op_t              op_reg, op_next;
    logic                        sck_reg, sck_next;
    logic                        mosi_reg, mosi_next;
    logic                        cs_reg, cs_next;
    logic                        rst_pin_reg, rst_pin_next;
    logic [7:0]                  tx_reg, tx_next;
    logic [7:0]                  rx_reg, rx_next;
    logic [2:0]                  bit_reg, bit_next;
    logic [COUNTER_BITS-1:0]     wait_reg, wait_next;
    logic [spims_pkg::RBC_W-1:0] rbc_reg, rbc_next;
    logic                        phase_reg, phase_next;

    logic [COUNTER_BITS-1:0] half_load, tmo_load, settle_load, wait_dec;
    logic [spims_pkg::RBC_W:0] rbc_inc;

    // shifter step shared by both transfer states
    logic                    sh_done, sh_sck, sh_mosi, sh_phase;
    logic [7:0]              sh_tx, sh_rx;
    logic [2:0]              sh_bit;
    logic [COUNTER_BITS-1:0] sh_wait;

    logic done, rdy, tmo;

    assign half_load   = wait_load(spims_pkg::TICK_W'(cfg.half_period_ticks));
    assign tmo_load    = wait_load(cfg.ready_timeout_ticks);
    assign settle_load = wait_load(cfg.settle_ticks);
    assign wait_dec    = wait_reg - COUNTER_BITS'(wait_reg != '0);
    assign rbc_inc     = {1'b0, rbc_reg} + (spims_pkg::RBC_W+1)'(1);

    always_comb
    begin
        sh_done  = 1'b0;
        sh_sck   = sck_reg;
        sh_mosi  = mosi_reg;
        sh_phase = phase_reg;
        sh_tx    = tx_reg;
        sh_rx    = rx_reg;
        sh_bit   = bit_reg;
        sh_wait  = wait_reg;
        if (wait_reg != '0)
        begin
            sh_wait = wait_dec;
        end
        else if (!phase_reg)
        begin
            sh_sck   = 1'b1;
            sh_phase = 1'b1;
            sh_wait  = half_load;
        end
        else
        begin
            sh_rx = {rx_reg[6:0], item.miso};
            if (bit_reg == 3'd7)
            begin
                sh_done = 1'b1;
            end
            else
            begin
                sh_bit   = bit_reg + 3'd1;
                sh_sck   = 1'b0;
                sh_mosi  = tx_reg[7];
                sh_tx    = {tx_reg[6:0], 1'b0};
                sh_phase = 1'b0;
                sh_wait  = half_load;
            end
        end
    end

    always_comb
    begin
        op_next      = op_reg;
        sck_next     = sck_reg;
        mosi_next    = mosi_reg;
        cs_next      = cs_reg;
        rst_pin_next = rst_pin_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        bit_next     = bit_reg;
        wait_next    = wait_reg;
        rbc_next     = rbc_reg;
        phase_next   = phase_reg;
        done         = 1'b0;
        rdy          = 1'b0;
        tmo          = 1'b0;
        unique case (op_reg)
            spims_pkg::OP_IDLE:
            begin
                case (spims_pkg::cmd_t'(item.command))
                    spims_pkg::CMD_XFER:
                    begin
                        sck_next   = 1'b0;
                        mosi_next  = item.tx_byte[7];
                        tx_next    = {item.tx_byte[6:0], 1'b0};
                        bit_next   = 3'd0;
                        phase_next = 1'b0;
                        wait_next  = half_load;
                        op_next    = spims_pkg::OP_XFER;
                    end
                    spims_pkg::CMD_SELECT, spims_pkg::CMD_DESELECT:
                    begin
                        cs_next   = (spims_pkg::cmd_t'(item.command) == spims_pkg::CMD_DESELECT);
                        wait_next = half_load;
                        op_next   = spims_pkg::OP_CSWAIT;
                    end
                    spims_pkg::CMD_SET_RST:
                    begin
                        rst_pin_next = item.reset_level;
                        done         = 1'b1;
                    end
                    spims_pkg::CMD_WAIT_RDY:
                    begin
                        if (!item.drdy_n)
                        begin
                            done = 1'b1;
                            rdy  = 1'b1;
                        end
                        else
                        begin
                            wait_next = tmo_load;
                            if (tmo_load == '0)
                            begin
                                done = 1'b1;
                                tmo  = 1'b1;
                            end
                            else
                            begin
                                op_next = spims_pkg::OP_READY;
                            end
                        end
                    end
                    spims_pkg::CMD_IF_RESET:
                    begin
                        cs_next   = 1'b0;
                        wait_next = half_load;
                        rbc_next  = '0;
                        op_next   = spims_pkg::OP_IR_SEL;
                    end
                    default:
                    begin
                    end
                endcase
            end
            spims_pkg::OP_XFER:
            begin
                sck_next   = sh_sck;
                mosi_next  = sh_mosi;
                phase_next = sh_phase;
                tx_next    = sh_tx;
                rx_next    = sh_rx;
                bit_next   = sh_bit;
                wait_next  = sh_wait;
                if (sh_done)
                begin
                    done    = 1'b1;
                    op_next = spims_pkg::OP_IDLE;
                end
            end
            spims_pkg::OP_READY:
            begin
                if (!item.drdy_n)
                begin
                    done    = 1'b1;
                    rdy     = 1'b1;
                    op_next = spims_pkg::OP_IDLE;
                end
                else
                begin
                    wait_next = wait_dec;
                    if (wait_dec == '0)
                    begin
                        done    = 1'b1;
                        tmo     = 1'b1;
                        op_next = spims_pkg::OP_IDLE;
                    end
                end
            end
            spims_pkg::OP_IR_SEL:
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_dec;
                end
                else
                begin
                    sck_next   = 1'b0;
                    mosi_next  = spims_pkg::IR_BYTE[7];
                    tx_next    = {spims_pkg::IR_BYTE[6:0], 1'b0};
                    bit_next   = 3'd0;
                    phase_next = 1'b0;
                    wait_next  = half_load;
                    op_next    = spims_pkg::OP_IR_XFER;
                end
            end
            spims_pkg::OP_IR_XFER:
            begin
                rx_next = sh_rx;
                if (!sh_done)
                begin
                    sck_next   = sh_sck;
                    mosi_next  = sh_mosi;
                    phase_next = sh_phase;
                    tx_next    = sh_tx;
                    bit_next   = sh_bit;
                    wait_next  = sh_wait;
                end
                else if (rbc_inc >= (spims_pkg::RBC_W+1)'(RESET_BYTES))
                begin
                    cs_next   = 1'b1;
                    wait_next = half_load;
                    op_next   = spims_pkg::OP_IR_DESEL;
                end
                else
                begin
                    rbc_next   = rbc_inc[spims_pkg::RBC_W-1:0];
                    sck_next   = 1'b0;
                    mosi_next  = spims_pkg::IR_BYTE[7];
                    tx_next    = {spims_pkg::IR_BYTE[6:0], 1'b0};
                    bit_next   = 3'd0;
                    phase_next = 1'b0;
                    wait_next  = half_load;
                end
            end
            spims_pkg::OP_IR_DESEL:
            begin
                if (wait_reg != '0)
                begin
                    wait_next = wait_dec;
                end
                else
                begin
                    wait_next = settle_load;
                    op_next   = spims_pkg::OP_IR_SETTLE;
                end
            end
            default:
            begin
                // cs wait and settle wait
                if (wait_reg != '0)
                begin
                    wait_next = wait_dec;
                end
                else
                begin
                    done    = 1'b1;
                    op_next = spims_pkg::OP_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg      <= spims_pkg::OP_IDLE;
            sck_reg     <= 1'b1;
            mosi_reg    <= 1'b0;
            cs_reg      <= 1'b1;
            rst_pin_reg <= 1'b1;
            tx_reg      <= '0;
            rx_reg      <= '0;
            bit_reg     <= '0;
            wait_reg    <= '0;
            rbc_reg     <= '0;
            phase_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            op_reg      <= op_next;
            sck_reg     <= sck_next;
            mosi_reg    <= mosi_next;
            cs_reg      <= cs_next;
            rst_pin_reg <= rst_pin_next;
            tx_reg      <= tx_next;
            rx_reg      <= rx_next;
            bit_reg     <= bit_next;
            wait_reg    <= wait_next;
            rbc_reg     <= rbc_next;
            phase_reg   <= phase_next;
        end
    end

    always_comb
    begin
        res.sck        = sck_next;
        res.mosi       = mosi_next;
        res.cs_n       = cs_next;
        res.adc_reset  = rst_pin_next;
        res.busy_res   = (op_next != spims_pkg::OP_IDLE);
        res.done_res   = done;
        res.rx_byte    = rx_next;
        res.ready_seen = rdy;
        res.timed_out  = tmo;
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && res.done_res) |-> !res.busy_res)
        else $error("command finished but sequencer still busy");

    a_cs_wait_count: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && op_reg == spims_pkg::OP_CSWAIT && wait_reg != '0)
        |=> (wait_reg == $past(wait_reg) - COUNTER_BITS'(1)))
        else $error("chip select wait did not count down");

endmodule

// ===== sv/spi_mode3_master_sequencer_top.sv =====
// path: an item goes through the input register, then the result register; one item
// per cycle while results are taken; each item advances the sequencer by one tick
// an input register and a result register separate the sides, so a stalled result
// still lets one more item in
// reset: cs_n, sck and adc_reset high, mosi low, sequencer idle, registers at defaults
module spi_mode3_master_sequencer_top #(
    parameter int COUNTER_BITS = 24,
    parameter int RESET_BYTES  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], tx_byte[10:3], reset_level[11], miso[12], drdy_n[13], zero[15:14]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sck[0], mosi[1], cs_n[2], adc_reset[3], busy_res[4], done_res[5], rx_byte[13:6],
    // ready_seen[14], timed_out[15]
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    spims_pkg::cfg_t    cfg;
    spims_pkg::item_t   in_data_reg;
    spims_pkg::result_t out_data_reg;
    spims_pkg::result_t res;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    spims_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spims_core #(
        .COUNTER_BITS (COUNTER_BITS),
        .RESET_BYTES  (RESET_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("pending item lost while result side stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule
